@@ rtl/core/psf_utp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_utp_pkg: shared types and constants for the PSF unicode table parser
// Separator and start-of-sequence codes for both font formats, plus the
// result record carried through the output stage.
// ----------------------------------------------------------------------------
package psf_utp_pkg;

    // Format select
    localparam logic FMT_PSF1 = 1'b0;
    localparam logic FMT_PSF2 = 1'b1;

    // PSF1 16-bit unit codes
    localparam logic [15:0] PSF1_SEP   = 16'hFFFF;
    localparam logic [15:0] PSF1_START = 16'hFFFE;

    // PSF2 byte codes
    localparam logic [7:0] PSF2_SEP   = 8'hFF;
    localparam logic [7:0] PSF2_START = 8'hFE;

    // One result item
    typedef struct packed {
        logic        bad_sequence;
        logic [15:0] glyph_number;
        logic [15:0] code_point;
    } psf_result_t;

endpackage

@@ rtl/core/psf_unicode_table_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_unicode_table_parser: PSF1/PSF2 font unicode table decoder
// Results are registered in the output stage before they appear on m_*.
// One table unit per cycle while s_tready high; state update is combinational.
// A two-entry output stage (result register plus skid register) keeps input
// open while one result waits; input is also held during a mode write transfer.
// aresetn (sync, active low) selects PSF2 mode, glyph number 1, and clears
// decoder and output state.
// ----------------------------------------------------------------------------
module psf_unicode_table_parser #(
    parameter int GLYPH_INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: format_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // table units
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] table_unit
    input  logic        s_tlast,   // end_of_table
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_point, [31:16] glyph_number
    output logic        m_tuser    // bad_sequence
);
    import psf_utp_pkg::*;

    localparam logic [GLYPH_INDEX_BITS-1:0] GLYPH_ONE = {{(GLYPH_INDEX_BITS-1){1'b0}}, 1'b1};

    // Decoder state
    logic                        format_mode_reg, format_mode_next;
    logic [GLYPH_INDEX_BITS-1:0] glyph_counter_reg, glyph_counter_next;
    logic                        skipping_reg, skipping_next;
    logic [15:0]                 utf8_acc_reg, utf8_acc_next;
    logic [2:0]                  bytes_rem_reg, bytes_rem_next;

    // Output stage
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    psf_result_t out_data_reg, out_data_next;
    psf_result_t skid_data_reg, skid_data_next;

    logic                         in_xfer;
    logic                         res_valid;
    psf_result_t                  res;
    logic [7:0]                   unit_byte;
    logic [2:0]                   lead_len;
    logic [7:0]                   lead_mask;
    logic [GLYPH_INDEX_BITS+15:0] glyph_ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg && !cfg_valid;
    assign in_xfer   = s_tvalid && s_tready;
    assign unit_byte = s_tdata[7:0];
    assign glyph_ext = {16'd0, glyph_counter_reg};

    // Lead byte decode: sequence length and payload mask
    always_comb begin
        unique case (unit_byte) inside
            [8'hC0:8'hDF]: begin lead_len = 3'd2; lead_mask = 8'h1F; end
            [8'hE0:8'hEF]: begin lead_len = 3'd3; lead_mask = 8'h0F; end
            [8'hF0:8'hF7]: begin lead_len = 3'd4; lead_mask = 8'h07; end
            [8'hF8:8'hFB]: begin lead_len = 3'd5; lead_mask = 8'h03; end
            default:       begin lead_len = 3'd6; lead_mask = 8'h01; end
        endcase
    end

    // Per-unit state update and result
    always_comb begin
        format_mode_next   = format_mode_reg;
        glyph_counter_next = glyph_counter_reg;
        skipping_next      = skipping_reg;
        utf8_acc_next      = utf8_acc_reg;
        bytes_rem_next     = bytes_rem_reg;
        res_valid          = 1'b0;
        res.code_point     = 16'd0;
        res.glyph_number   = glyph_ext[15:0];
        res.bad_sequence   = 1'b0;

        if (cfg_valid && cfg_ready) begin
            // mode write restarts the parser
            format_mode_next   = cfg_data;
            glyph_counter_next = {{(GLYPH_INDEX_BITS-1){1'b0}}, cfg_data};
            skipping_next      = 1'b0;
            utf8_acc_next      = 16'd0;
            bytes_rem_next     = 3'd0;
        end else if (in_xfer) begin
            if (format_mode_reg == FMT_PSF1) begin
                if (s_tdata == PSF1_SEP) begin
                    glyph_counter_next = glyph_counter_reg + GLYPH_ONE;
                    skipping_next      = 1'b0;
                end else if (skipping_reg) begin
                    // dropped
                end else if (s_tdata == PSF1_START) begin
                    skipping_next = 1'b1;
                end else begin
                    res_valid      = 1'b1;
                    res.code_point = s_tdata;
                end
            end else begin
                if (bytes_rem_reg != 3'd0) begin
                    // continuation byte, any value
                    utf8_acc_next  = {utf8_acc_reg[9:0], unit_byte[5:0]};
                    bytes_rem_next = bytes_rem_reg - 3'd1;
                    if (bytes_rem_next == 3'd0) begin
                        res_valid      = 1'b1;
                        res.code_point = utf8_acc_next;
                    end
                end else if (unit_byte == PSF2_SEP) begin
                    glyph_counter_next = glyph_counter_reg + GLYPH_ONE;
                    skipping_next      = 1'b0;
                end else if (skipping_reg) begin
                    // dropped
                end else if (unit_byte == PSF2_START) begin
                    skipping_next = 1'b1;
                end else if (!unit_byte[7]) begin
                    res_valid      = 1'b1;
                    res.code_point = {8'd0, unit_byte};
                end else if (!unit_byte[6]) begin
                    // stray continuation byte as a one-byte code
                    res_valid      = 1'b1;
                    res.code_point = {10'd0, unit_byte[5:0]};
                end else begin
                    utf8_acc_next  = {8'd0, unit_byte & lead_mask};
                    bytes_rem_next = lead_len - 3'd1;
                end
                // table end inside a sequence
                if (s_tlast && bytes_rem_next != 3'd0) begin
                    res_valid        = 1'b1;
                    res.code_point   = 16'd0;
                    res.bad_sequence = 1'b1;
                end
            end
            if (s_tlast) begin
                glyph_counter_next = {{(GLYPH_INDEX_BITS-1){1'b0}}, format_mode_reg};
                skipping_next      = 1'b0;
                utf8_acc_next      = 16'd0;
                bytes_rem_next     = 3'd0;
            end
        end
    end

    // Output register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg   <= FMT_PSF2;
            glyph_counter_reg <= GLYPH_ONE;
            skipping_reg      <= 1'b0;
            utf8_acc_reg      <= 16'd0;
            bytes_rem_reg     <= 3'd0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            format_mode_reg   <= format_mode_next;
            glyph_counter_reg <= glyph_counter_next;
            skipping_reg      <= skipping_next;
            utf8_acc_reg      <= utf8_acc_next;
            bytes_rem_reg     <= bytes_rem_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.glyph_number, out_data_reg.code_point};
    assign m_tuser  = out_data_reg.bad_sequence;

`ifndef SYNTHESIS
    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // PSF1 never holds a partial UTF-8 sequence
    a_psf1_no_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (format_mode_reg == FMT_PSF1) |-> (bytes_rem_reg == 3'd0))
        else $error("pending UTF-8 bytes in PSF1 mode");

    // truncation flag always carries a zero code point
    a_bad_zero_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'd0))
        else $error("bad_sequence result with nonzero code point");

    // table end leaves the decoder idle
    a_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tlast) |=> (bytes_rem_reg == 3'd0 && !skipping_reg))
        else $error("decoder state not restarted after table end");
`endif

endmodule
